// ----- hw/rtl/lsdt_pkg.sv -----
// Package for the limit switch debounce and trip block.
// Holds the axis count, field widths, register defaults, register and direction codes and result structs.
// No dependencies.
package lsdt_pkg;

	localparam int AXES         = 3;
	localparam int IN_AXES      = 3;
	localparam int CNT_W        = 16;
	localparam int TRIP_AXIS_W  = 2;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CNT_W-1:0] DEBOUNCE_DEFAULT = 16'd100;
	localparam logic [CNT_W-1:0] BLANK_DEFAULT    = 16'd40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 1'b0,
		REG_BLANK    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_UNKNOWN = 2'd0,
		DIR_POS     = 2'd1,
		DIR_NEG     = 2'd2
	} dir_t;

	typedef struct packed {
		logic [CNT_W-1:0] hit_pass;
		logic [CNT_W-1:0] hit_next;
		logic [CNT_W-1:0] blank_next;
		dir_t             dir_next;
		logic             trip;
	} lane_res_t;

	typedef struct packed {
		logic                   trip;
		logic [TRIP_AXIS_W-1:0] axis;
		logic [AXES-1:0]        keep;
	} merge_res_t;

	typedef struct packed {
		logic                   trip;
		logic [TRIP_AXIS_W-1:0] axis;
		logic                   latched;
	} result_t;

endpackage

// ----- hw/rtl/lsdt_lane.sv -----
// Per-axis lane: direction tracking, blanking window and saturating debounce count.
// Depends on lsdt_pkg.
module lsdt_lane
	import lsdt_pkg::*;
(
	input  logic [CNT_W-1:0] hit_count,
	input  logic [CNT_W-1:0] blank_count,
	input  dir_t             prev_dir,
	input  logic             dir_bit,
	input  logic             min_bit,
	input  logic             max_bit,
	input  logic [CNT_W-1:0] debounce_ticks,
	input  logic [CNT_W-1:0] blank_ticks,
	output lane_res_t        res
);

	dir_t             cur_dir;
	dir_t             ref_dir;
	logic             flip;
	logic             watched;
	logic [CNT_W-1:0] hit0;
	logic [CNT_W-1:0] blank_n;
	logic [CNT_W-1:0] hit_inc;

	always_comb begin
		cur_dir = dir_bit ? DIR_POS : DIR_NEG;
		ref_dir = (prev_dir == DIR_UNKNOWN) ? cur_dir : prev_dir;
		flip    = (cur_dir != ref_dir);
		if (flip) begin
			blank_n = blank_ticks;
		end else if (blank_count != '0) begin
			blank_n = blank_count - CNT_W'(1);
		end else begin
			blank_n = blank_count;
		end
		hit0    = flip ? '0 : hit_count;
		watched = dir_bit ? max_bit : min_bit;
		hit_inc = (hit0 < debounce_ticks) ? hit0 + CNT_W'(1) : hit0;

		res.hit_pass   = hit0;
		res.blank_next = blank_n;
		res.dir_next   = cur_dir;
		if (blank_n != '0) begin
			res.hit_next = '0;
			res.trip     = 1'b0;
		end else if (watched) begin
			res.hit_next = hit_inc;
			res.trip     = (hit_inc >= debounce_ticks);
		end else begin
			res.hit_next = '0;
			res.trip     = 1'b0;
		end
	end

endmodule

// ----- hw/rtl/lsdt_merge.sv -----
// Merging stage: picks the lowest tripping axis and marks which lanes commit their counts.
// Depends on lsdt_pkg.
module lsdt_merge
	import lsdt_pkg::*;
(
	input  logic [AXES-1:0] lane_trip,
	output merge_res_t      res
);

	always_comb begin
		res.trip = 1'b0;
		res.axis = '0;
		res.keep = '0;
		for (int a = 0; a < AXES; a++) begin
			res.keep[a] = !res.trip;
			if (!res.trip && lane_trip[a]) begin
				res.trip = 1'b1;
				res.axis = TRIP_AXIS_W'(a);
			end
		end
	end

endmodule

// ----- hw/rtl/limit_switch_debounce_trip.sv -----
// Directional limit switch detector with integrating debounce and direction-flip blanking.
// Each result is registered in the output register, or in the skid entry while the output is stalled;
// throughput one beat per cycle while in_stall is low. A two-entry output stage (register plus skid)
// keeps input stall a registered signal. Reset clears counters, trip latch and directions, and loads
// the default register values. Depends on lsdt_pkg, lsdt_lane and lsdt_merge.
module limit_switch_debounce_trip
	import lsdt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CNT_W-1:0]       cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   motion_active,
	input  logic                   error_present,
	input  logic [IN_AXES-1:0]     dir_positive,
	input  logic [IN_AXES-1:0]     min_switch,
	input  logic [IN_AXES-1:0]     max_switch,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   trip,
	output logic [TRIP_AXIS_W-1:0] trip_axis,
	output logic                   latched
);

	logic [CNT_W-1:0] debounce_q;
	logic [CNT_W-1:0] blank_ticks_q;
	logic [CNT_W-1:0] hit_q   [AXES];
	logic [CNT_W-1:0] blank_q [AXES];
	dir_t             dir_q   [AXES];
	logic             latch_q;

	logic [CNT_W-1:0] hit_d   [AXES];
	logic [CNT_W-1:0] blank_d [AXES];
	dir_t             dir_d   [AXES];
	logic             latch_d;

	lane_res_t        lane_res [AXES];
	logic [AXES-1:0]  lane_trip;
	merge_res_t       mrg;
	result_t          res;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    in_fire;
	logic    out_fire;
	logic    run;

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		logic dir_b;
		logic min_b;
		logic max_b;
		if (a < IN_AXES) begin : g_in
			assign dir_b = dir_positive[a];
			assign min_b = min_switch[a];
			assign max_b = max_switch[a];
		end else begin : g_zero
			assign dir_b = 1'b0;
			assign min_b = 1'b0;
			assign max_b = 1'b0;
		end
		lsdt_lane u_lane (
			.hit_count      (hit_q[a]),
			.blank_count    (blank_q[a]),
			.prev_dir       (dir_q[a]),
			.dir_bit        (dir_b),
			.min_bit        (min_b),
			.max_bit        (max_b),
			.debounce_ticks (debounce_q),
			.blank_ticks    (blank_ticks_q),
			.res            (lane_res[a])
		);
		assign lane_trip[a] = lane_res[a].trip;
	end

	lsdt_merge u_merge (
		.lane_trip (lane_trip),
		.res       (mrg)
	);

	assign run = motion_active && !latch_q && !error_present;

	always_comb begin
		latch_d = latch_q;
		for (int a = 0; a < AXES; a++) begin
			hit_d[a]   = hit_q[a];
			blank_d[a] = blank_q[a];
			dir_d[a]   = dir_q[a];
		end
		priority if (!motion_active) begin
			latch_d = 1'b0;
			for (int a = 0; a < AXES; a++) begin
				hit_d[a]   = '0;
				blank_d[a] = '0;
			end
		end else if (latch_q) begin
			latch_d = 1'b1;
		end else if (error_present) begin
			latch_d = 1'b1;
			for (int a = 0; a < AXES; a++) begin
				hit_d[a] = '0;
			end
		end else begin
			latch_d = mrg.trip;
			for (int a = 0; a < AXES; a++) begin
				dir_d[a]   = lane_res[a].dir_next;
				blank_d[a] = lane_res[a].blank_next;
				hit_d[a]   = mrg.keep[a] ? lane_res[a].hit_next : lane_res[a].hit_pass;
			end
		end
		res.trip    = run && mrg.trip;
		res.axis    = run ? mrg.axis : '0;
		res.latched = latch_d;
	end

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= DEBOUNCE_DEFAULT;
			blank_ticks_q <= BLANK_DEFAULT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE: debounce_q    <= cfg_wdata;
				REG_BLANK:    blank_ticks_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				hit_q[a]   <= '0;
				blank_q[a] <= '0;
				dir_q[a]   <= DIR_UNKNOWN;
			end
		end else if (in_fire) begin
			latch_q <= latch_d;
			for (int a = 0; a < AXES; a++) begin
				hit_q[a]   <= hit_d[a];
				blank_q[a] <= blank_d[a];
				dir_q[a]   <= dir_d[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res;
			end
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign trip      = out_q.trip;
	assign trip_axis = out_q.axis;
	assign latched   = out_q.latched;

`ifndef SYNTHESIS
	a_trip_latches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trip |-> latched)
		else $error("trip beat without latched state");

	a_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !trip |-> trip_axis == '0)
		else $error("trip axis nonzero without trip");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !motion_active |=> !latch_q && hit_q[0] == '0)
		else $error("inactive motion did not clear latch and counters");
`endif

endmodule

// ----- tb/limit_switch_debounce_trip_chk.sv -----
// Checker for the limit switch debounce and trip block: tracks register writes, predicts
// the trip result of every accepted input beat and compares each output beat with it.
// Depends on lsdt_pkg.
module limit_switch_debounce_trip_chk
	import lsdt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CNT_W-1:0]       cfg_wdata,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   motion_active,
	input  logic                   error_present,
	input  logic [IN_AXES-1:0]     dir_positive,
	input  logic [IN_AXES-1:0]     min_switch,
	input  logic [IN_AXES-1:0]     max_switch,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   trip,
	input  logic [TRIP_AXIS_W-1:0] trip_axis,
	input  logic                   latched,
	output int                     mismatches,
	output int                     outstanding,
	output int                     trips_seen,
	output int                     results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CNT_W-1:0] deb_limit;
	logic [CNT_W-1:0] blank_limit;
	logic [CNT_W-1:0] hits [AXES];
	logic [CNT_W-1:0] blanks [AXES];
	dir_t             heading [AXES];
	logic             trip_held;
	result_t          due_trip_status [$];
	result_t          want;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		mismatches++;
		if (mismatches <= 200) begin
			$display("mismatch at result %0d: %s is %0d, expected %0d",
				results_seen, what, got, exp_val);
		end
	endtask

	function automatic result_t step_limits(input logic motion, input logic err,
			input logic [IN_AXES-1:0] dirs, input logic [IN_AXES-1:0] mins,
			input logic [IN_AXES-1:0] maxs);
		result_t r;
		dir_t    d;
		logic    watched;
		logic    done;
		r = '0;
		done = 1'b0;
		if (!motion) begin
			for (int a = 0; a < AXES; a++) begin
				hits[a] = '0;
				blanks[a] = '0;
			end
			trip_held = 1'b0;
		end else if (trip_held) begin
		end else if (err) begin
			for (int a = 0; a < AXES; a++) begin
				hits[a] = '0;
			end
			trip_held = 1'b1;
		end else begin
			for (int a = 0; a < AXES; a++) begin
				d = dirs[a] ? DIR_POS : DIR_NEG;
				if (heading[a] == DIR_UNKNOWN) begin
					heading[a] = d;
				end
				if (d != heading[a]) begin
					heading[a] = d;
					blanks[a] = blank_limit;
					hits[a] = '0;
				end else if (blanks[a] != '0) begin
					blanks[a] = blanks[a] - CNT_W'(1);
				end
			end
			for (int a = 0; a < AXES; a++) begin
				if (!done) begin
					if (blanks[a] != '0) begin
						hits[a] = '0;
					end else begin
						watched = dirs[a] ? maxs[a] : mins[a];
						if (watched) begin
							if (hits[a] < deb_limit) begin
								hits[a] = hits[a] + CNT_W'(1);
							end
							if (hits[a] >= deb_limit) begin
								r.trip = 1'b1;
								r.axis = TRIP_AXIS_W'(a);
								done = 1'b1;
							end
						end else begin
							hits[a] = '0;
						end
					end
				end
			end
			if (r.trip) begin
				trip_held = 1'b1;
			end
		end
		r.latched = trip_held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_limit = DEBOUNCE_DEFAULT;
			blank_limit = BLANK_DEFAULT;
			for (int a = 0; a < AXES; a++) begin
				hits[a] = '0;
				blanks[a] = '0;
				heading[a] = DIR_UNKNOWN;
			end
			trip_held = 1'b0;
			due_trip_status.delete();
			mismatches = 0;
			outstanding <= 0;
			trips_seen <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_DEBOUNCE: deb_limit = cfg_wdata;
					REG_BLANK:    blank_limit = cfg_wdata;
					default:      ;
				endcase
			end
			if (in_valid && !in_stall) begin
				due_trip_status.push_back(step_limits(motion_active, error_present,
					dir_positive, min_switch, max_switch));
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (due_trip_status.size() == 0) begin
					report_mismatch("beat with nothing expected, fields",
						int'({trip, trip_axis, latched}), 0);
				end else begin
					want = due_trip_status.pop_front();
					if (trip !== want.trip) begin
						report_mismatch("trip", int'(trip), int'(want.trip));
					end
					if (trip_axis !== want.axis) begin
						report_mismatch("trip_axis", int'(trip_axis), int'(want.axis));
					end
					if (latched !== want.latched) begin
						report_mismatch("latched", int'(latched), int'(want.latched));
					end
				end
				results_seen <= results_seen + 1;
				if (trip === 1'b1) begin
					trips_seen <= trips_seen + 1;
				end
			end
			outstanding <= due_trip_status.size();
		end
	end

endmodule

// ----- tb/limit_switch_debounce_trip_tb.sv -----
// Testbench top for limit_switch_debounce_trip: clock, reset, register writes, tick stimulus
// with bursts and output stalls, and the final verdict.
// Depends on lsdt_pkg, limit_switch_debounce_trip and limit_switch_debounce_trip_chk.
module limit_switch_debounce_trip_tb
	import lsdt_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CNT_W-1:0]       cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	logic                   motion_active;
	logic                   error_present;
	logic [IN_AXES-1:0]     dir_positive;
	logic [IN_AXES-1:0]     min_switch;
	logic [IN_AXES-1:0]     max_switch;
	logic                   out_valid;
	logic                   out_stall;
	logic                   trip;
	logic [TRIP_AXIS_W-1:0] trip_axis;
	logic                   latched;

	int mismatches;
	int outstanding;
	int trips_seen;
	int results_seen;
	int ticks_sent;
	int settings_used;
	int burst_left;
	int squeeze_ask;
	logic [IN_AXES-1:0] walk_dir;
	logic [IN_AXES-1:0] walk_min;
	logic [IN_AXES-1:0] walk_max;

	limit_switch_debounce_trip dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.motion_active (motion_active),
		.error_present (error_present),
		.dir_positive  (dir_positive),
		.min_switch    (min_switch),
		.max_switch    (max_switch),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.trip          (trip),
		.trip_axis     (trip_axis),
		.latched       (latched)
	);

	limit_switch_debounce_trip_chk chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.motion_active (motion_active),
		.error_present (error_present),
		.dir_positive  (dir_positive),
		.min_switch    (min_switch),
		.max_switch    (max_switch),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.trip          (trip),
		.trip_axis     (trip_axis),
		.latched       (latched),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.trips_seen    (trips_seen),
		.results_seen  (results_seen)
	);

	always #1 clk = ~clk;

	task automatic send_tick(input logic motion, input logic err,
			input logic [IN_AXES-1:0] dirs, input logic [IN_AXES-1:0] mins,
			input logic [IN_AXES-1:0] maxs);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		motion_active <= motion;
		error_present <= err;
		dir_positive <= dirs;
		min_switch <= mins;
		max_switch <= maxs;
		do @(posedge clk); while (in_stall !== 1'b0);
		ticks_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] blank);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_wdata <= deb;
		@(posedge clk);
		cfg_index <= REG_BLANK;
		cfg_wdata <= blank;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Mostly steady motion with slowly changing switches, so the debounce counters can
	// actually reach their limit; the rest is stops, external errors and random noise.
	task automatic random_ticks(input int count, input int flip, input int churn,
			input int noisy);
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < noisy) begin
				case ($urandom_range(0, 3))
					0: send_tick(1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
						3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
					1: send_tick(1'b1, 1'b1, 3'($urandom_range(0, 7)),
						3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
					default: send_tick(1'b1, 1'b0, 3'($urandom_range(0, 7)),
						3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
				endcase
			end else begin
				if ($urandom_range(0, 99) < flip) begin
					walk_dir ^= IN_AXES'(1 << $urandom_range(0, IN_AXES - 1));
				end
				if ($urandom_range(0, 99) < churn) begin
					walk_max ^= IN_AXES'(1 << $urandom_range(0, IN_AXES - 1));
				end
				if ($urandom_range(0, 99) < churn) begin
					walk_min ^= IN_AXES'(1 << $urandom_range(0, IN_AXES - 1));
				end
				send_tick(1'b1, 1'b0, walk_dir, walk_min, walk_max);
			end
		end
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] blank,
			input int count, input int flip, input int churn, input int noisy,
			input logic squeeze);
		settle();
		set_limits(deb, blank);
		if (squeeze) begin
			squeeze_ask++;
		end
		random_ticks(count, flip, churn, noisy);
	endtask

	initial begin : receiver
		int hold_left;
		int mode;
		int mode_left;
		int squeeze_done;
		out_stall = 1'b0;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		squeeze_done = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (squeeze_done != squeeze_ask) begin
				squeeze_done = squeeze_ask;
				hold_left = 59;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 50);
				end
				mode_left--;
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		#400_000;
		$display("** limit_switch_debounce_trip: FAILED **");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		motion_active = 1'b0;
		error_present = 1'b0;
		dir_positive = '0;
		min_switch = '0;
		max_switch = '0;
		ticks_sent = 0;
		settings_used = 0;
		burst_left = 0;
		squeeze_ask = 0;
		walk_dir = 3'($urandom_range(0, 7));
		walk_min = 3'($urandom_range(0, 7));
		walk_max = 3'($urandom_range(0, 7));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_limits(16'd2, 16'd2);
		send_tick(1'b0, 1'b1, 3'b111, 3'b111, 3'b111);
		send_tick(1'b1, 1'b0, 3'b111, 3'b111, 3'b000);
		send_tick(1'b1, 1'b0, 3'b111, 3'b000, 3'b111);
		send_tick(1'b1, 1'b0, 3'b111, 3'b000, 3'b111);
		send_tick(1'b1, 1'b0, 3'b111, 3'b000, 3'b111);
		send_tick(1'b1, 1'b1, 3'b111, 3'b000, 3'b111);
		send_tick(1'b0, 1'b0, 3'b000, 3'b000, 3'b000);
		repeat (4) send_tick(1'b1, 1'b0, 3'b000, 3'b100, 3'b000);
		send_tick(1'b0, 1'b0, 3'b000, 3'b000, 3'b000);
		send_tick(1'b1, 1'b1, 3'b000, 3'b111, 3'b111);
		send_tick(1'b1, 1'b0, 3'b000, 3'b111, 3'b111);
		send_tick(1'b0, 1'b0, 3'b000, 3'b000, 3'b000);
		settle();
		set_limits(16'd0, 16'd0);
		send_tick(1'b1, 1'b0, 3'b010, 3'b000, 3'b010);
		send_tick(1'b0, 1'b0, 3'b010, 3'b000, 3'b000);
		send_tick(1'b1, 1'b0, 3'b010, 3'b000, 3'b000);
		settle();
		set_limits(16'hFFFF, 16'hFFFF);
		repeat (3) send_tick(1'b1, 1'b0, 3'b101, 3'b111, 3'b111);
		send_tick(1'b0, 1'b0, 3'b101, 3'b111, 3'b111);

		run_phase(16'd2, 16'd1, 110, 3, 10, 10, 1'b0);
		run_phase(16'd1, 16'd0, 80, 3, 20, 15, 1'b0);
		run_phase(16'd5, 16'd3, 110, 3, 8, 8, 1'b1);
		run_phase(16'd0, 16'd2, 60, 5, 20, 15, 1'b0);
		run_phase(16'hFFFF, 16'd0, 50, 3, 20, 10, 1'b0);
		run_phase(16'd3, 16'hFFFF, 60, 2, 10, 10, 1'b0);
		run_phase(DEBOUNCE_DEFAULT, BLANK_DEFAULT, 160, 1, 1, 2, 1'b0);
		run_phase(16'd4, 16'd6, 120, 3, 10, 10, 1'b1);
		run_phase(16'd1, 16'd1, 80, 4, 15, 10, 1'b0);
		settle();
		repeat (8) @(posedge clk);

		$display("Run covered %0d ticks under %0d register settings, including stops, errors,",
			ticks_sent, settings_used);
		$display("direction flips and output back-pressure; %0d of %0d result beats were trips.",
			trips_seen, results_seen);
		if (mismatches == 0) begin
			$display("** limit_switch_debounce_trip: PASSED **");
		end else begin
			$display("** limit_switch_debounce_trip: FAILED **");
		end
		$finish;
	end

endmodule
